// ----- hw/rtl/mvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsm_pkg
// shared types, constants and downmix tables of the surround mixer
// ----------------------------------------------------------------------------
`default_nettype none

package mvsm_pkg;

  localparam int VOICE_COUNT       = 16;
  localparam int VOICE_BITS        = 4;
  localparam int SAMPLES_PER_VOICE = 16384;
  localparam int POS_BITS          = 14;
  localparam int LEN_BITS          = 15;
  localparam int MEM_ADDR_BITS     = VOICE_BITS + POS_BITS;
  localparam int MEM_DEPTH         = VOICE_COUNT * SAMPLES_PER_VOICE;
  localparam int ACC_BITS          = 46;
  localparam int OUT_CHANNELS      = 6;

  localparam logic [15:0] GAIN_RESET = 16'd4096;
  localparam logic [15:0] COEF_0707  = 16'd46334;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LAYOUT_MONO   = 2'd0,
    LAYOUT_STEREO = 2'd1,
    LAYOUT_51     = 2'd2,
    LAYOUT_71     = 2'd3
  } layout_t;

  typedef enum logic [1:0] {
    MIX_NONE = 2'd0,
    MIX_ONE  = 2'd1,
    MIX_HALF = 2'd2,
    MIX_707  = 2'd3
  } mix_t;

  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [MEM_ADDR_BITS-1:0] addr;
    logic [23:0]              wdata;
  } mem_req_t;

  function automatic logic [3:0] chan_count(input logic [1:0] lay);
    logic [3:0] n;
    case (lay)
      LAYOUT_MONO:   n = 4'd1;
      LAYOUT_STEREO: n = 4'd2;
      LAYOUT_51:     n = 4'd6;
      default:       n = 4'd8;
    endcase
    return n;
  endfunction

  // weight of interleaved channel k of a frame on output channel j
  function automatic mix_t mix_code(input logic [1:0] lay, input logic [2:0] k,
                                    input logic [2:0] j);
    mix_t m;
    m = MIX_NONE;
    case (lay)
      LAYOUT_MONO: begin
        if (j == 3'd0 || j == 3'd1) m = MIX_707;
        else if (j == 3'd2) m = MIX_ONE;
      end
      LAYOUT_STEREO: begin
        if (j == 3'd2) m = MIX_HALF;
        else if (j == k) m = MIX_ONE;
      end
      LAYOUT_51: begin
        if (j == k) m = MIX_ONE;
      end
      default: begin
        // back pair folds into the sides, side pair goes straight
        if (k < 3'd4) begin
          if (j == k) m = MIX_ONE;
        end else if (k < 3'd6) begin
          if (j == k) m = MIX_707;
        end else if (j == k - 3'd2) begin
          m = MIX_ONE;
        end
      end
    endcase
    return m;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
    logic signed [23:0] r;
    if (x > 48'sd8388607) r = 24'sh7fffff;
    else if (x < -48'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mvsm_sample_ram.sv -----
// ----------------------------------------------------------------------------
// mvsm_sample_ram
// single port sample store, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_sample_ram
  import mvsm_pkg::*;
(
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic      [23:0] rdata
);

  logic [23:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsm_engine.sv -----
// ----------------------------------------------------------------------------
// mvsm_engine
// voice table, load scaling, render sequencer, accumulators and output stage
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_engine
  import mvsm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [1:0]             op,
  input  wire logic [VOICE_BITS-1:0]  voice,
  input  wire logic [POS_BITS-1:0]    sample_addr,
  input  wire logic signed [23:0]     sample_value,
  input  wire logic [15:0]            voice_gain,
  input  wire logic [1:0]             layout,
  input  wire logic [LEN_BITS-1:0]    sample_count,
  input  wire logic [15:0]            master_gain,
  output logic                        busy,
  output mem_req_t                    mem_req,
  input  wire logic [23:0]            mem_rdata,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [23:0]          res [OUT_CHANNELS]
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_MUL, ST_LOAD_WR, ST_CHECK, ST_READ,
    ST_DRAIN, ST_OUT_MUL, ST_OUT_SUM, ST_DONE
  } state_t;

  state_t state;

  logic [POS_BITS:0]   vpos [VOICE_COUNT];
  logic [LEN_BITS-1:0] vlen [VOICE_COUNT];
  logic [1:0]          vlay [VOICE_COUNT];

  logic [VOICE_BITS-1:0] lvoice;
  logic [POS_BITS-1:0]   laddr;
  logic signed [23:0]    lsample;
  logic [15:0]           lgain;
  logic signed [40:0]    lprod;

  logic [VOICE_BITS-1:0] vidx;
  logic [2:0]            kidx;
  logic [1:0]            drain_cnt;
  logic [2:0]            cidx;

  logic                  t1_valid;
  logic [1:0]            t1_lay;
  logic [2:0]            t1_k;
  logic                  t2_valid;
  logic [1:0]            t2_lay;
  logic [2:0]            t2_k;
  logic signed [23:0]    rd1;
  logic signed [40:0]    p707;

  logic signed [ACC_BITS-1:0] acc [OUT_CHANNELS];
  logic signed [46:0]         ohi;
  logic [31:0]                olo;
  logic signed [23:0]         mix [OUT_CHANNELS];

  logic [1:0]          cur_lay;
  logic [3:0]          cur_ch;
  logic [POS_BITS:0]   cur_pos;
  logic                active;
  logic [POS_BITS:0]   rd_off;
  logic signed [47:0]  load_q;
  logic signed [63:0]  out_total;
  logic signed [23:0]  out_sat;
  logic                last_k;

  assign cur_lay = vlay[vidx];
  assign cur_ch  = chan_count(cur_lay);
  assign cur_pos = vpos[vidx];
  assign active  = ({1'b0, cur_pos} + 16'(cur_ch)) <= {1'b0, vlen[vidx]};
  assign rd_off  = cur_pos + (POS_BITS+1)'(kidx);
  assign last_k  = (kidx == 3'(cur_ch - 4'd1));

  assign load_q    = (48'(lprod) + 48'sd2048) >>> 12;
  assign out_total = (64'(ohi) <<< 16) + $signed({32'd0, olo}) + 64'sd134217728;
  assign out_sat   = sat24($signed(out_total[63:16]) >>> 12);

  assign busy = (state != ST_IDLE);

  always_comb begin
    mem_req.we    = (state == ST_LOAD_WR);
    mem_req.re    = (state == ST_READ);
    mem_req.wdata = sat24(load_q);
    if (state == ST_LOAD_WR) begin
      mem_req.addr = {lvoice, laddr};
    end else begin
      mem_req.addr = {vidx, rd_off[POS_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        vpos[i] <= '0;
        vlen[i] <= '0;
        vlay[i] <= '0;
      end
    end else begin
      // a finished frame goes out once the previous one has been taken
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        for (int j = 0; j < OUT_CHANNELS; j++) res[j] <= mix[j];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // read tag pipeline, in step with the memory read
      t1_valid <= (state == ST_READ);
      t1_lay   <= cur_lay;
      t1_k     <= kidx;
      t2_valid <= t1_valid;
      t2_lay   <= t1_lay;
      t2_k     <= t1_k;
      rd1      <= mem_rdata;
      p707     <= $signed(mem_rdata) * $signed({1'b0, COEF_0707});

      if (t2_valid) begin
        for (int j = 0; j < OUT_CHANNELS; j++) begin
          case (mix_code(t2_lay, t2_k, 3'(j)))
            MIX_ONE:  acc[j] <= acc[j] + {{6{rd1[23]}}, rd1, 16'd0};
            MIX_HALF: acc[j] <= acc[j] + {{7{rd1[23]}}, rd1, 15'd0};
            MIX_707:  acc[j] <= acc[j] + {{5{p707[40]}}, p707};
            default:  acc[j] <= acc[j];
          endcase
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            case (op)
              OP_LOAD: begin
                lvoice  <= voice;
                laddr   <= sample_addr;
                lsample <= sample_value;
                lgain   <= voice_gain;
                if ({1'b0, voice} < (VOICE_BITS+1)'(VOICE_COUNT)) begin
                  state <= ST_LOAD_MUL;
                end
              end
              OP_START: begin
                if ({1'b0, voice} < (VOICE_BITS+1)'(VOICE_COUNT)) begin
                  vlay[voice] <= layout;
                  vpos[voice] <= '0;
                  if (sample_count > LEN_BITS'(SAMPLES_PER_VOICE)) begin
                    vlen[voice] <= LEN_BITS'(SAMPLES_PER_VOICE);
                  end else begin
                    vlen[voice] <= sample_count;
                  end
                end
              end
              OP_RENDER: begin
                for (int j = 0; j < OUT_CHANNELS; j++) acc[j] <= '0;
                vidx  <= '0;
                kidx  <= '0;
                state <= ST_CHECK;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LOAD_MUL: begin
          lprod <= lsample * $signed({1'b0, lgain});
          state <= ST_LOAD_WR;
        end
        ST_LOAD_WR: begin
          state <= ST_IDLE;
        end
        ST_CHECK: begin
          kidx <= '0;
          if (active) begin
            state <= ST_READ;
          end else if (vidx == VOICE_BITS'(VOICE_COUNT - 1)) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        ST_READ: begin
          kidx <= kidx + 1'b1;
          if (last_k) begin
            vpos[vidx] <= cur_pos + (POS_BITS+1)'(cur_ch);
            if (vidx == VOICE_BITS'(VOICE_COUNT - 1)) begin
              drain_cnt <= '0;
              state     <= ST_DRAIN;
            end else begin
              vidx  <= vidx + 1'b1;
              state <= ST_CHECK;
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          cidx      <= '0;
          if (drain_cnt == 2'd2) begin
            state <= ST_OUT_MUL;
          end
        end
        ST_OUT_MUL: begin
          ohi   <= $signed(acc[cidx][ACC_BITS-1:16]) * $signed({1'b0, master_gain});
          olo   <= acc[cidx][15:0] * master_gain;
          state <= ST_OUT_SUM;
        end
        ST_OUT_SUM: begin
          mix[cidx] <= out_sat;
          cidx      <= cidx + 1'b1;
          if (cidx == 3'(OUT_CHANNELS - 1)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_OUT_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_voice_surround_mixer.sv -----
// ----------------------------------------------------------------------------
// multi_voice_surround_mixer
// mixes up to sixteen stored voices into one 5.1 output frame
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall) carries load, start and render
// transactions; output channel (out_valid / out_stall) carries one 5.1 frame
// per render. master_gain sits at byte address 0 of the APB port.
// load passes a multiply step and a memory write step; start and unknown
// ops are taken in the idle step. render checks each voice, then the voice
// walk reads one sample per cycle from the single sample memory port, then
// the read pipeline drains and six output channels pass the gain multiplier
// one after another.
// in_stall is high while a transaction is being worked on.
// reset idles all voices, sets master_gain to unity and drops out_valid;
// sample memory contents are left as they are.
// a finished frame waits in the output register while out_stall is high;
// the next transaction is still accepted, and a following render holds in
// its last step until the earlier frame is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_surround_mixer
  import mvsm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             op,
  input  wire logic [VOICE_BITS-1:0]  voice,
  input  wire logic [POS_BITS-1:0]    sample_addr,
  input  wire logic signed [23:0]     sample_value,
  input  wire logic [15:0]            voice_gain,
  input  wire logic [1:0]             layout,
  input  wire logic [LEN_BITS-1:0]    sample_count,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [23:0]          front_left,
  output logic signed [23:0]          front_right,
  output logic signed [23:0]          front_center,
  output logic signed [23:0]          low_freq,
  output logic signed [23:0]          side_left,
  output logic signed [23:0]          side_right
);

  logic [15:0]        master_gain;
  logic               busy;
  mem_req_t           mem_req;
  logic [23:0]        mem_rdata;
  logic signed [23:0] res [OUT_CHANNELS];

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {16'd0, master_gain} : 32'd0;
  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      master_gain <= pwdata[15:0];
    end
  end

  mvsm_sample_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mvsm_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid && !busy),
    .op           (op),
    .voice        (voice),
    .sample_addr  (sample_addr),
    .sample_value (sample_value),
    .voice_gain   (voice_gain),
    .layout       (layout),
    .sample_count (sample_count),
    .master_gain  (master_gain),
    .busy         (busy),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res          (res)
  );

  assign front_left   = res[0];
  assign front_right  = res[1];
  assign front_center = res[2];
  assign low_freq     = res[3];
  assign side_left    = res[4];
  assign side_right   = res[5];

endmodule

`default_nettype wire

// ----- hw/rtl/mvsm_checker.sv -----
// ----------------------------------------------------------------------------
// mvsm_checker
// port level checks of the surround mixer
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_checker
  import mvsm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  op,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] front_left
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("mixer not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_left))
    else $error("stalled frame changed");

  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_RENDER |=> in_stall)
    else $error("render transaction did not occupy the block");

  a_no_frame_from_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op != OP_RENDER && !out_valid |=> !out_valid)
    else $error("frame without render");

  a_gain_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == 1'b0
    |=> paddr[2] != 1'b0 || prdata[15:0] == $past(pwdata[15:0]))
    else $error("master gain readback mismatch");

endmodule

bind multi_voice_surround_mixer mvsm_checker u_mvsm_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .op         (op),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .front_left (front_left)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the surround mixer: a directed table, then random
// load / start / render traffic checked against a frame predictor, with
// random idling on both channels and master_gain changed between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mvsm_pkg::*;

  localparam int    ITEM_TARGET = 1050;
  localparam int    DRAIN_WAIT  = 200;
  localparam int    HOLD_CYCLES = 600;
  localparam int    CYCLE_LIMIT = 3000000;
  localparam longint C707  = 46334;
  localparam longint CHALF = 32768;
  localparam longint CONE  = 65536;

  typedef struct packed {
    logic signed [23:0] fl, fr, fc, lfe, sl, sr;
  } frame_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [VOICE_BITS-1:0]   voice;
    logic [POS_BITS-1:0]     addr;
    logic signed [23:0]      value;
    logic [15:0]             gain;
    logic [1:0]              layout;
    logic [LEN_BITS-1:0]     count;
    logic                    typed;
    frame_t                  frame;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [VOICE_BITS-1:0] voice = '0;
  logic [POS_BITS-1:0] sample_addr = '0;
  logic signed [23:0] sample_value = '0;
  logic [15:0] voice_gain = '0;
  logic [1:0] layout = '0;
  logic [LEN_BITS-1:0] sample_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] front_left, front_right, front_center;
  logic signed [23:0] low_freq, side_left, side_right;

  multi_voice_surround_mixer u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [23:0] mix_store [MEM_DEPTH];
  bit                 mix_written [MEM_DEPTH];
  int unsigned        play_pos [VOICE_COUNT];
  int unsigned        play_len [VOICE_COUNT];
  logic [1:0]         play_lay [VOICE_COUNT];
  longint             gain_q;

  frame_t frame_q[$];
  int     errors = 0;
  int     sent = 0;
  bit     calm = 1'b0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     cycles = 0;

  function automatic logic signed [23:0] clip24(input longint x);
    if (x > 8388607) return 24'sh7fffff;
    if (x < -8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic int unsigned chans(input logic [1:0] lay);
    case (lay)
      LAYOUT_MONO:   return 1;
      LAYOUT_STEREO: return 2;
      LAYOUT_51:     return 6;
      default:       return 8;
    endcase
  endfunction

  function automatic longint rd(input int unsigned v, input int unsigned k);
    return longint'(mix_store[v * SAMPLES_PER_VOICE + play_pos[v] + k]);
  endfunction

  function automatic frame_t render_frame();
    longint acc [6];
    longint y;
    int unsigned ch;
    frame_t f;
    foreach (acc[j]) acc[j] = 0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      ch = chans(play_lay[v]);
      if (play_pos[v] + ch <= play_len[v]) begin
        case (play_lay[v])
          LAYOUT_MONO: begin
            acc[0] += rd(v, 0) * C707;
            acc[1] += rd(v, 0) * C707;
            acc[2] += rd(v, 0) * CONE;
          end
          LAYOUT_STEREO: begin
            acc[0] += rd(v, 0) * CONE;
            acc[1] += rd(v, 1) * CONE;
            acc[2] += rd(v, 0) * CHALF + rd(v, 1) * CHALF;
          end
          LAYOUT_51: begin
            for (int j = 0; j < 6; j++) acc[j] += rd(v, j) * CONE;
          end
          default: begin
            for (int j = 0; j < 4; j++) acc[j] += rd(v, j) * CONE;
            // back pair folds into the sides
            acc[4] += rd(v, 6) * CONE + rd(v, 4) * C707;
            acc[5] += rd(v, 7) * CONE + rd(v, 5) * C707;
          end
        endcase
        play_pos[v] += ch;
      end
    end
    y = (acc[0] * gain_q + (64'sd1 <<< 27)) >>> 28; f.fl  = clip24(y);
    y = (acc[1] * gain_q + (64'sd1 <<< 27)) >>> 28; f.fr  = clip24(y);
    y = (acc[2] * gain_q + (64'sd1 <<< 27)) >>> 28; f.fc  = clip24(y);
    y = (acc[3] * gain_q + (64'sd1 <<< 27)) >>> 28; f.lfe = clip24(y);
    y = (acc[4] * gain_q + (64'sd1 <<< 27)) >>> 28; f.sl  = clip24(y);
    y = (acc[5] * gain_q + (64'sd1 <<< 27)) >>> 28; f.sr  = clip24(y);
    return f;
  endfunction

  function automatic void predict(input row_t r);
    int unsigned idx;
    int unsigned cnt;
    frame_t f;
    case (r.op)
      OP_LOAD: begin
        idx = {r.voice, r.addr};
        mix_store[idx] = clip24((longint'(r.value) * longint'(r.gain) + 2048) >>> 12);
        mix_written[idx] = 1'b1;
      end
      OP_START: begin
        cnt = r.count;
        if (cnt > SAMPLES_PER_VOICE) cnt = SAMPLES_PER_VOICE;
        play_lay[r.voice] = r.layout;
        play_len[r.voice] = cnt;
        play_pos[r.voice] = 0;
      end
      OP_RENDER: begin
        f = render_frame();
        frame_q = {frame_q, (r.typed ? r.frame : f)};
      end
      default: ;
    endcase
  endfunction

  task automatic drive(input row_t r);
    if (!calm && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = r.op;
    voice = r.voice;
    sample_addr = r.addr;
    sample_value = r.value;
    voice_gain = r.gain;
    layout = r.layout;
    sample_count = r.count;
    do @(posedge clk); while (in_stall);
    predict(r);
    sent++;
  endtask

  function automatic row_t blank(input logic [1:0] o);
    row_t r;
    r = '0;
    r.op = o;
    r.voice = $urandom;
    r.addr = $urandom;
    r.value = $urandom;
    r.gain = $urandom;
    r.layout = $urandom;
    r.count = $urandom;
    return r;
  endfunction

  // a render must never read a sample that was never loaded
  task automatic render_item(input row_t r);
    row_t ld;
    int unsigned ch;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      ch = chans(play_lay[v]);
      if (play_pos[v] + ch <= play_len[v]) begin
        for (int k = 0; k < ch; k++) begin
          if (!mix_written[v * SAMPLES_PER_VOICE + play_pos[v] + k]) begin
            ld = blank(OP_LOAD);
            ld.voice = v;
            ld.addr = play_pos[v] + k;
            drive(ld);
          end
        end
      end
    end
    drive(r);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    gain_q = d[15:0];
  endtask

  task automatic settle();
    wait (frame_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic row_t mk(input logic [1:0] o, input logic [3:0] v,
                              input logic [13:0] a, input logic signed [23:0] s,
                              input logic [15:0] g, input logic [1:0] l,
                              input logic [14:0] c, input logic t, input frame_t f);
    row_t r;
    r = '{o, v, a, s, g, l, c, t, f};
    return r;
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    frame_t e;
    if (!rst && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $error("output transaction with no frame expected");
        errors++;
      end else begin
        e = frame_q.pop_front();
        if (front_left !== e.fl) begin
          $error("front_left exp %0d got %0d", e.fl, front_left); errors++;
        end
        if (front_right !== e.fr) begin
          $error("front_right exp %0d got %0d", e.fr, front_right); errors++;
        end
        if (front_center !== e.fc) begin
          $error("front_center exp %0d got %0d", e.fc, front_center); errors++;
        end
        if (low_freq !== e.lfe) begin
          $error("low_freq exp %0d got %0d", e.lfe, low_freq); errors++;
        end
        if (side_left !== e.sl) begin
          $error("side_left exp %0d got %0d", e.sl, side_left); errors++;
        end
        if (side_right !== e.sr) begin
          $error("side_right exp %0d got %0d", e.sr, side_right); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t dir [$];
    row_t r;
    frame_t z, mixed;
    int unsigned pick;
    int seg_end;
    logic [15:0] gains [4];
    z = '0;
    mixed = '{24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000,
              24'sh7fffff, 24'sh800000};
    gains = '{16'hffff, 16'h0000, 16'($urandom), GAIN_RESET};
    foreach (play_pos[v]) begin
      play_pos[v] = 0; play_len[v] = 0; play_lay[v] = LAYOUT_MONO;
    end
    gain_q = GAIN_RESET;

    // nothing playing after reset, unknown op, a saturating 5.1 voice,
    // then mono, stereo and a 7.1 voice with an over-long length
    dir = {dir, mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 1, z)};
    dir = {dir, mk(OP_NONE, 7, 14'h3fff, 24'sh7fffff, 16'hffff, 3, 15'h7fff, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 0, 24'sh7fffff, 16'd4096, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 1, 24'sh7fffff, 16'hffff, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 2, 24'sh800000, 16'd4096, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 3, 24'sh800000, 16'hffff, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 4, 24'sh7fffff, 16'd4096, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 1, 5, 24'sh800000, 16'd4096, 0, 0, 0, z)};
    dir = {dir, mk(OP_START, 1, 0, 0, 0, LAYOUT_51, 15'd6, 0, z)};
    dir = {dir, mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 1, mixed)};
    dir = {dir, mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 1, z)};
    dir = {dir, mk(OP_LOAD, 2, 0, -24'sd1, 16'd1, 0, 0, 0, z)};
    dir = {dir, mk(OP_START, 2, 0, 0, 0, LAYOUT_MONO, 15'd1, 0, z)};
    dir = {dir, mk(OP_LOAD, 3, 0, 24'sd123456, 16'd8000, 0, 0, 0, z)};
    dir = {dir, mk(OP_LOAD, 3, 1, -24'sd654321, 16'd3000, 0, 0, 0, z)};
    dir = {dir, mk(OP_START, 3, 0, 0, 0, LAYOUT_STEREO, 15'd2, 0, z)};
    for (int k = 0; k < 8; k++)
      dir = {dir, mk(OP_LOAD, 15, k, 24'sd400000 * (k - 3), 16'd4096 + k * 977,
                     0, 0, 0, z)};
    dir = {dir, mk(OP_START, 15, 0, 0, 0, LAYOUT_71, 15'h7fff, 0, z)};
    dir = {dir, mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, z)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir[i]) begin
      if (dir[i].op == OP_RENDER) render_item(dir[i]);
      else drive(dir[i]);
    end

    for (int seg = 0; seg < 4; seg++) begin
      @(negedge clk);
      in_valid = 1'b0;
      settle();
      apb_write(3'd0, {16'h0, gains[seg]});
      calm = (seg == 2);
      if (seg == 1) hold_req++;
      // fill loads ahead of a render count toward the item budget
      seg_end = sent + (ITEM_TARGET - sent) / (4 - seg);
      while (sent < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 38) begin
          render_item(blank(OP_RENDER));
        end else if (pick < 55) begin
          r = blank(OP_START);
          case ($urandom_range(9))
            0: r.count = 15'd16384 + $urandom_range(16383);
            1: r.count = $urandom_range(16);
            default: r.count = chans(r.layout) * $urandom_range(1, 6);
          endcase
          drive(r);
        end else if (pick < 95) begin
          r = blank(OP_LOAD);
          if ($urandom_range(9) != 0) r.addr = $urandom_range(63);
          drive(r);
        end else begin
          drive(blank(OP_NONE));
        end
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mvsm_pkg.sv
hw/rtl/mvsm_sample_ram.sv
hw/rtl/mvsm_engine.sv
hw/rtl/multi_voice_surround_mixer.sv
hw/rtl/mvsm_checker.sv
test/tb.sv
